// ===== src/las_pkg.sv =====
// ============================================================================
// las_pkg
// Shared types and constants for the local alignment score block.
// ============================================================================
`default_nettype none

package las_pkg;

  localparam int MAX_QUERY   = 256;
  localparam int MAX_SUBJECT = 65536;

  localparam int SYM_W   = 8;
  localparam int QIDX_W  = $clog2(MAX_QUERY);
  localparam int LEN_W   = $clog2(MAX_QUERY + 1);
  localparam int COL_W   = $clog2(MAX_SUBJECT + 1);
  localparam int SCORE_W = 15;
  localparam int CALC_W  = SCORE_W + 2;
  localparam int MR_W    = 7;
  localparam int PEN_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;

  localparam logic signed [CALC_W-1:0] SCORE_TOP = CALC_W'((1 << SCORE_W) - 1);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CIDX_W-1:0] REG_GAP      = 2'd2;

  // operation codes
  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  localparam logic [MR_W-1:0]         MATCH_RST    = 7'd5;
  localparam logic signed [PEN_W-1:0] MISMATCH_RST = -8'sd3;
  localparam logic signed [PEN_W-1:0] GAP_RST      = -8'sd7;

  typedef struct packed {
    logic [MR_W-1:0]         match_reward;
    logic signed [PEN_W-1:0] mismatch_penalty;
    logic signed [PEN_W-1:0] gap_penalty;
  } cfg_t;

  // one subject symbol moving down the row of cells
  typedef struct packed {
    logic             valid;
    logic             compute;
    logic             first;
    logic             last;
    logic [SYM_W-1:0] sym;
    logic [COL_W-1:0] col;
  } token_t;

  // best score seen so far along the row
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } best_t;

endpackage

`default_nettype wire

// ===== src/las_if.sv =====
// ============================================================================
// las_in_if / las_out_if
// Valid/ready channels for query and subject symbols and for results.
// ============================================================================
`default_nettype none

interface las_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [las_pkg::SYM_W-1:0] symbol;
  logic                     last;

  modport source (output valid, output operation, output symbol, output last, input ready);
  modport sink   (input valid, input operation, input symbol, input last, output ready);
endinterface

interface las_out_if;
  logic                        valid;
  logic                        ready;
  logic [las_pkg::SCORE_W-1:0] best_score;
  logic [las_pkg::LEN_W-1:0]   best_row;
  logic [las_pkg::COL_W-1:0]   best_column;

  modport source (output valid, output best_score, output best_row, output best_column,
                  input ready);
  modport sink   (input valid, input best_score, input best_row, input best_column,
                  output ready);
endinterface

`default_nettype wire

// ===== src/las_cell.sv =====
// ============================================================================
// las_cell
// One query row of the score matrix: computes one cell per subject symbol.
// ============================================================================
`default_nettype none

module las_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire las_pkg::cfg_t                 cfg,
  input  wire logic [las_pkg::LEN_W-1:0]     row,
  input  wire logic                          active,
  input  wire logic                          q_we,
  input  wire logic [las_pkg::SYM_W-1:0]     q_sym,
  input  wire las_pkg::token_t               tok_in,
  input  wire logic [las_pkg::SCORE_W-1:0]   up_in,
  input  wire las_pkg::best_t                carry_in,
  output las_pkg::token_t                    tok_out,
  output logic [las_pkg::SCORE_W-1:0]        h_out,
  output las_pkg::best_t                     carry_out
);

  localparam int PAD_W = las_pkg::CALC_W - las_pkg::SCORE_W;

  logic [las_pkg::SYM_W-1:0]   q_r;
  logic [las_pkg::SCORE_W-1:0] left_r;
  logic [las_pkg::SCORE_W-1:0] diag_r;
  logic [las_pkg::SCORE_W-1:0] best_r;
  logic [las_pkg::COL_W-1:0]   best_col_r;
  las_pkg::token_t             tok_r;
  logic [las_pkg::SCORE_W-1:0] h_r;
  las_pkg::best_t              carry_r;

  logic                              do_calc;
  logic signed [las_pkg::CALC_W-1:0] diag_s, left_s, up_s, step_s, gap_s;
  logic signed [las_pkg::CALC_W-1:0] d_s, u_s, l_s, h_s;
  logic [las_pkg::SCORE_W-1:0]       h_nxt;
  logic [las_pkg::SCORE_W-1:0]       base_score;
  logic [las_pkg::COL_W-1:0]         base_col;
  logic [las_pkg::SCORE_W-1:0]       best_nxt;
  logic [las_pkg::COL_W-1:0]         best_col_nxt;
  las_pkg::best_t                    carry_nxt;

  assign do_calc = tok_in.valid && tok_in.compute && active;

  always_comb begin
    // first column of a subject sees zero on the left and diagonal
    diag_s = tok_in.first ? '0 : {{PAD_W{1'b0}}, diag_r};
    left_s = tok_in.first ? '0 : {{PAD_W{1'b0}}, left_r};
    up_s   = {{PAD_W{1'b0}}, up_in};
    gap_s  = {{(las_pkg::CALC_W - las_pkg::PEN_W){cfg.gap_penalty[las_pkg::PEN_W-1]}},
              cfg.gap_penalty};
    if (q_r == tok_in.sym) begin
      step_s = {{(las_pkg::CALC_W - las_pkg::MR_W){1'b0}}, cfg.match_reward};
    end else begin
      step_s = {{(las_pkg::CALC_W - las_pkg::PEN_W){cfg.mismatch_penalty[las_pkg::PEN_W-1]}},
                cfg.mismatch_penalty};
    end
    d_s = diag_s + step_s;
    u_s = up_s + gap_s;
    l_s = left_s + gap_s;
    h_s = '0;
    if (d_s > h_s) begin
      h_s = d_s;
    end
    if (u_s > h_s) begin
      h_s = u_s;
    end
    if (l_s > h_s) begin
      h_s = l_s;
    end
    if (h_s > las_pkg::SCORE_TOP) begin
      h_s = las_pkg::SCORE_TOP;
    end
    h_nxt = h_s[las_pkg::SCORE_W-1:0];

    base_score = tok_in.first ? '0 : best_r;
    base_col   = tok_in.first ? '0 : best_col_r;
    if (do_calc && (h_nxt > base_score)) begin
      best_nxt     = h_nxt;
      best_col_nxt = tok_in.col;
    end else begin
      best_nxt     = base_score;
      best_col_nxt = base_col;
    end

    // an earlier row wins a tie, so the incoming value is kept on equal scores
    if (active && (best_nxt > carry_in.score)) begin
      carry_nxt.score = best_nxt;
      carry_nxt.row   = row;
      carry_nxt.col   = best_col_nxt;
    end else begin
      carry_nxt = carry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_r <= q_sym;
    end
    if (do_calc) begin
      diag_r     <= up_in;
      left_r     <= h_nxt;
      best_r     <= best_nxt;
      best_col_r <= best_col_nxt;
    end
    h_r     <= h_nxt;
    carry_r <= carry_nxt;
  end

  assign tok_out   = tok_r;
  assign h_out     = h_r;
  assign carry_out = carry_r;

endmodule

`default_nettype wire

// ===== src/local_alignment_score.sv =====
// ============================================================================
// local_alignment_score
// Smith-Waterman local alignment score with linear gap over a row of cells.
// ============================================================================
// The result is registered once the subject symbol that carries last has
//   passed the input register, one stage per cell and one result stage.
// Throughput: one query or subject symbol per cycle; after a last subject
//   symbol no input is taken until the result transfer.
// Reset: synchronous, active low; clears the query, subject and result state
//   and restores the register defaults 5, -3 and -7.
`default_nettype none

module local_alignment_score (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  las_in_if.sink                              in_chan,
  las_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [las_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [las_pkg::CDATA_W-1:0]    cfg_data
);

  las_pkg::cfg_t             cfg_r;
  logic [las_pkg::LEN_W-1:0] query_len_r;
  logic                      query_closed_r;
  logic                      subject_active_r;
  logic [las_pkg::COL_W-1:0] subject_pos_r;
  logic                      busy_r;
  las_pkg::token_t           inject_r;
  logic                      out_valid_r;
  las_pkg::best_t            out_r;

  logic                       in_xfer;
  logic                       out_xfer;
  logic [las_pkg::LEN_W-1:0]  len_base;
  logic                       q_we_any;
  logic [las_pkg::QIDX_W-1:0] q_idx;
  logic [las_pkg::COL_W-1:0]  pos_base;
  logic                       pos_ok;

  las_pkg::token_t             tok   [0:las_pkg::MAX_QUERY];
  logic [las_pkg::SCORE_W-1:0] h     [0:las_pkg::MAX_QUERY];
  las_pkg::best_t              carry [0:las_pkg::MAX_QUERY];
  las_pkg::token_t             tok_end;

  assign in_chan.ready = !busy_r;
  assign in_xfer       = in_chan.valid && !busy_r;
  assign out_xfer      = out_valid_r && out_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_reward     <= las_pkg::MATCH_RST;
      cfg_r.mismatch_penalty <= las_pkg::MISMATCH_RST;
      cfg_r.gap_penalty      <= las_pkg::GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        las_pkg::REG_MATCH:    cfg_r.match_reward     <= cfg_data[las_pkg::MR_W-1:0];
        las_pkg::REG_MISMATCH: cfg_r.mismatch_penalty <= cfg_data[las_pkg::PEN_W-1:0];
        las_pkg::REG_GAP:      cfg_r.gap_penalty      <= cfg_data[las_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: query loading and subject column numbering
  always_comb begin
    len_base = query_closed_r ? '0 : query_len_r;
    q_we_any = in_xfer && (in_chan.operation == las_pkg::OP_QUERY) &&
               (len_base < las_pkg::LEN_W'(las_pkg::MAX_QUERY));
    q_idx    = len_base[las_pkg::QIDX_W-1:0];
    pos_base = subject_active_r ? subject_pos_r : '0;
    pos_ok   = pos_base < las_pkg::COL_W'(las_pkg::MAX_SUBJECT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_len_r      <= '0;
      query_closed_r   <= 1'b0;
      subject_active_r <= 1'b0;
      subject_pos_r    <= '0;
      busy_r           <= 1'b0;
      inject_r         <= '0;
    end else begin
      inject_r.valid <= in_xfer && (in_chan.operation == las_pkg::OP_SUBJECT);
      if (out_xfer) begin
        busy_r <= 1'b0;
      end
      if (in_xfer) begin
        if (in_chan.operation == las_pkg::OP_QUERY) begin
          subject_active_r <= 1'b0;
          subject_pos_r    <= '0;
          query_len_r      <= q_we_any ? len_base + 1'b1 : len_base;
          query_closed_r   <= in_chan.last;
        end else begin
          query_closed_r   <= 1'b1;
          subject_active_r <= !in_chan.last;
          if (in_chan.last) begin
            subject_pos_r <= '0;
            busy_r        <= 1'b1;
          end else if (pos_ok) begin
            subject_pos_r <= pos_base + 1'b1;
          end else begin
            subject_pos_r <= pos_base;
          end
          inject_r.compute <= pos_ok;
          inject_r.first   <= !subject_active_r;
          inject_r.last    <= in_chan.last;
          inject_r.sym     <= in_chan.symbol;
          inject_r.col     <= pos_base + 1'b1;
        end
      end
    end
  end

  assign tok[0]   = inject_r;
  assign h[0]     = '0;
  assign carry[0] = '0;

  for (genvar i = 0; i < las_pkg::MAX_QUERY; i++) begin : g_cell
    las_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg_r),
      .row       (las_pkg::LEN_W'(i + 1)),
      .active    (las_pkg::LEN_W'(i) < query_len_r),
      .q_we      (q_we_any && (q_idx == las_pkg::QIDX_W'(i))),
      .q_sym     (in_chan.symbol),
      .tok_in    (tok[i]),
      .up_in     (h[i]),
      .carry_in  (carry[i]),
      .tok_out   (tok[i+1]),
      .h_out     (h[i+1]),
      .carry_out (carry[i+1])
    );
  end

  assign tok_end = tok[las_pkg::MAX_QUERY];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_end.valid && tok_end.last) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.valid && tok_end.last) begin
      out_r <= carry[las_pkg::MAX_QUERY];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.best_score  = out_r.score;
  assign out_chan.best_row    = out_r.row;
  assign out_chan.best_column = out_r.col;

  a_result_needs_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("result pending without a subject in progress");

  a_no_input_with_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_chan.ready)
    else $error("input taken while a result is pending");

  a_end_token_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
    (tok_end.valid && tok_end.last) |-> (busy_r && !out_valid_r))
    else $error("last subject symbol left the row with the result slot in use");

  a_query_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    query_len_r <= las_pkg::LEN_W'(las_pkg::MAX_QUERY))
    else $error("query length beyond row size");

  a_busy_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_chan.operation == las_pkg::OP_SUBJECT) && in_chan.last) |=> busy_r)
    else $error("last subject symbol did not hold off input");

endmodule

`default_nettype wire
